### rtl/cme_pkg.sv
// ----------------------------------------------------------------------------
// cme_pkg: shared definitions for the character modular exponentiation core
// Widths, register indexes, controller states and the modular add helper.
// ----------------------------------------------------------------------------
package cme_pkg;

  // Field and register widths.
  localparam int MODULUS_BITS  = 31;
  localparam int EXPONENT_BITS = 16;
  localparam int CHAR_BITS     = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (MODULUS_BITS > EXPONENT_BITS) ? MODULUS_BITS : EXPONENT_BITS;

  // Cycle counter covers both the byte reduction and one multiply pass.
  localparam int CNT_W = $clog2(MODULUS_BITS);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  typedef logic [MODULUS_BITS-1:0] mod_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_MUL,
    ST_DONE
  } state_e;

  // (a + b) mod n for a, b < n.
  function automatic mod_t add_mod(input mod_t a, input mod_t b, input mod_t n);
    logic [MODULUS_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[MODULUS_BITS-1:0];
  endfunction

endpackage

### rtl/char_modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// char_modular_exponentiation_core: per-character modular exponentiation
// Raises an 8-bit character code to a configured exponent modulo a
// configured modulus, using bit-serial square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Write the exponent (index 0) and the modulus (index 1) through cfg_we_i,
//   cfg_index_i and cfg_data_i while the core is idle. A zero modulus acts
//   as one. An item is accepted on a rising edge with start_i high and
//   busy_o low; busy_o stays high until the result has been shown.
//   The result appears on cipher_value_o for exactly one cycle with done_o
//   high; the receiver must take it then, it cannot stall the core.
// Operation:
//   The byte is first reduced modulo n, one bit per cycle. Then for each
//   exponent bit up to the highest set one, a load step and a shift-and-add
//   pass over all MODULUS_BITS multiplier bits run, doing the multiply
//   and the square side by side from one shared multiplier shift register.
//   One item at a time.
// Reset:
//   rst_ni clears the controller to idle, the exponent to 0, the modulus to 1.
// ----------------------------------------------------------------------------
module char_modular_exponentiation_core
  import cme_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CHAR_BITS-1:0]     char_code_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [MODULUS_BITS-1:0]  cipher_value_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [EXPONENT_BITS-1:0] exponent_q;
  mod_t                     modulus_q;
  mod_t                     n_eff;

  logic [CNT_W-1:0]         cnt_q;
  logic [CHAR_BITS-1:0]     char_q;
  logic [EXPONENT_BITS-1:0] exp_sh_q;

  mod_t result_q, sq_q;
  mod_t res_acc_q, res_x_q, sq_acc_q, sq_x_q, b_sh_q;
  mod_t res_acc_d, res_x_d, sq_acc_d, sq_x_d;
  mod_t red_d;
  logic [MODULUS_BITS:0] red_t;

  logic accept;
  logic red_last, mul_last;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign red_last = (cnt_q == CNT_W'(CHAR_BITS - 1));
  assign mul_last = (cnt_q == CNT_W'(MODULUS_BITS - 1));

  // A zero modulus behaves as one.
  assign n_eff = (modulus_q == '0) ? mod_t'(1) : modulus_q;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= '0;
      modulus_q  <= mod_t'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_EXPONENT: exponent_q <= cfg_data_i[EXPONENT_BITS-1:0];
        REG_MODULUS:  modulus_q  <= cfg_data_i[MODULUS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // Byte reduction step: shift in the next character bit, subtract n once.
  always_comb begin
    red_t = {sq_q, char_q[CHAR_BITS-1]};
    if (red_t >= {1'b0, n_eff}) begin
      red_t = red_t - {1'b0, n_eff};
    end
    red_d = red_t[MODULUS_BITS-1:0];
  end

  // One shift-and-add step for both products, driven by one multiplier bit.
  always_comb begin
    res_acc_d = b_sh_q[0] ? add_mod(res_acc_q, res_x_q, n_eff) : res_acc_q;
    sq_acc_d  = b_sh_q[0] ? add_mod(sq_acc_q, sq_x_q, n_eff) : sq_acc_q;
    res_x_d   = add_mod(res_x_q, res_x_q, n_eff);
    sq_x_d    = add_mod(sq_x_q, sq_x_q, n_eff);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_REDUCE;
      ST_REDUCE: if (red_last) state_d = ST_LOAD;
      ST_LOAD:   state_d = (exp_sh_q == '0) ? ST_DONE : ST_MUL;
      ST_MUL:    if (mul_last) state_d = ST_LOAD;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  assign cipher_value_o = result_q;

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_REDUCE: cnt_q <= red_last ? '0 : cnt_q + CNT_W'(1);
        ST_MUL:    cnt_q <= mul_last ? '0 : cnt_q + CNT_W'(1);
        default:   cnt_q <= '0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          char_q   <= char_code_i;
          exp_sh_q <= exponent_q;
          sq_q     <= '0;
        end
      end
      ST_REDUCE: begin
        sq_q   <= red_d;
        char_q <= {char_q[CHAR_BITS-2:0], 1'b0};
        // 1 mod n is zero only when n is one.
        if (red_last) begin
          result_q <= (n_eff == mod_t'(1)) ? '0 : mod_t'(1);
        end
      end
      ST_LOAD: begin
        res_acc_q <= '0;
        sq_acc_q  <= '0;
        res_x_q   <= result_q;
        sq_x_q    <= sq_q;
        b_sh_q    <= sq_q;
      end
      ST_MUL: begin
        res_acc_q <= res_acc_d;
        sq_acc_q  <= sq_acc_d;
        res_x_q   <= res_x_d;
        sq_x_q    <= sq_x_d;
        b_sh_q    <= {1'b0, b_sh_q[MODULUS_BITS-1:1]};
        // End of a pass: take the product if this exponent bit is set.
        if (mul_last) begin
          if (exp_sh_q[0]) begin
            result_q <= res_acc_d;
          end
          sq_q     <= sq_acc_d;
          exp_sh_q <= {1'b0, exp_sh_q[EXPONENT_BITS-1:1]};
        end
      end
      default: ;
    endcase
  end

endmodule
